// ===== rtl/radix_integer_to_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// radix integer to ascii assertion macros
// shared assertion shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TO_ASCII_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_DEFINES_SVH

// assertion gated by active-low reset
`define RITA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds while reset is applied
`define RITA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rita_pkg.sv =====
// ----------------------------------------------------------------------------
// rita_pkg
// types, constants and helpers of the radix integer to ascii block
// ----------------------------------------------------------------------------
package rita_pkg;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned DigitW     = 6;
  localparam int unsigned CountW     = 7;
  localparam int unsigned CharW      = 7;

  localparam logic [DigitW-1:0] BASE_MIN      = 6'd2;
  localparam logic [DigitW-1:0] BASE_MAX      = 6'd36;
  localparam logic [DigitW-1:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [CharW-1:0]  CHAR_ZERO     = 7'd48;
  localparam logic [CharW-1:0]  CHAR_LETTER_A = 7'd65;

  typedef struct packed {
    logic [63:0]       value;
    logic [DigitW-1:0] base;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DigitW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DigitW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_READ,
    S_SHOW
  } state_e;

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [DigitW-1:0] d);
    logic [CharW-1:0] dx;
    dx = {1'b0, d};
    if (d < DECIMAL_LIMIT) begin
      return dx + CHAR_ZERO;
    end
    return dx - {1'b0, DECIMAL_LIMIT} + CHAR_LETTER_A;
  endfunction

endpackage

// ===== rtl/rita_divider.sv =====
// ----------------------------------------------------------------------------
// rita_divider
// restoring shift-subtract divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rita_divider #(
  parameter int unsigned W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rita_pkg::div_req_t req_i,
  input  logic [W-1:0]      dividend_i,
  output rita_pkg::div_rsp_t rsp_o,
  output logic [W-1:0]      quotient_o
);
  import rita_pkg::*;

  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]      quo_q, quo_d;
  logic [DigitW-1:0] rem_q, rem_d;
  logic [DigitW-1:0] div_q, div_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DigitW:0]   trial;
  logic [DigitW:0]   dv;
  logic              ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign dv    = {1'b0, div_q};
  assign ge    = (trial >= dv);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // trial subtract of the divisor from the shifted partial remainder
      rem_d = ge ? DigitW'(trial - dv) : trial[DigitW-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;
  assign quotient_o      = quo_q;

endmodule

// ===== rtl/rita_digit_mem.sv =====
// ----------------------------------------------------------------------------
// rita_digit_mem
// digit store, one write and one registered read port
// ----------------------------------------------------------------------------
module rita_digit_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [rita_pkg::AddrW-1:0] waddr_i,
  input  logic [rita_pkg::DigitW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [rita_pkg::AddrW-1:0] raddr_i,
  output logic [rita_pkg::DigitW-1:0] rdata_o
);
  import rita_pkg::*;

  logic [DigitW-1:0] mem [StoreDepth];
  logic [DigitW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/radix_integer_to_ascii.sv =====
// ----------------------------------------------------------------------------
// radix_integer_to_ascii
// converts an unsigned value to ascii digits in a radix from 2 to 36
// ----------------------------------------------------------------------------
// digits: each digit takes one pass through the shared divider: a start state,
//   the shift-subtract steps, then a writeback of the remainder on done
// emission: each digit goes through a read state and a show state, since the store
//   read is registered; a new item is taken only once the previous last digit is accepted
// reset: rst_ni is asynchronous, active low; the block comes up idle and ready
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rita_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rita_pkg::out_t out_data_o
);
  import rita_pkg::*;

  // sequencer state
  state_e state_q, state_d;

  // running quotient, clamped radix, digit count, emission pointer
  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [DigitW-1:0]     base_q, base_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [AddrW-1:0]      emit_idx_q, emit_idx_d;

  // divider and store hookup
  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [VALUE_BITS-1:0] div_quot;
  logic                  mem_we;
  logic                  mem_re;
  logic [DigitW-1:0]     mem_rdata;

  logic                  in_beat;
  logic                  out_beat;
  logic [DigitW-1:0]     base_clamped;
  logic                  div_final;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  // radix clamp to the supported range
  always_comb begin
    base_clamped = in_data_i.base;
    if (in_data_i.base < BASE_MIN) begin
      base_clamped = BASE_MIN;
    end else if (in_data_i.base > BASE_MAX) begin
      base_clamped = BASE_MAX;
    end
  end

  // conversion stops once the quotient runs out or the store is full
  assign div_final = (div_quot == '0) || (count_q == CountW'(StoreDepth - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = div_final ? S_READ : S_START;
        end
      end
      S_READ: begin
        state_d = S_SHOW;
      end
      S_SHOW: begin
        if (out_beat) begin
          state_d = (emit_idx_q == '0) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath updates and control outputs
  always_comb begin
    quot_d          = quot_q;
    base_d          = base_q;
    count_d         = count_q;
    emit_idx_d      = emit_idx_q;
    div_req.start   = 1'b0;
    div_req.divisor = base_q;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_beat) begin
          // bits above VALUE_BITS are dropped here
          quot_d  = in_data_i.value[VALUE_BITS-1:0];
          base_d  = base_clamped;
          count_d = '0;
        end
      end
      S_START: begin
        div_req.start = 1'b1;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mem_we  = 1'b1;
          quot_d  = div_quot;
          count_d = count_q + 1'b1;
          if (div_final) begin
            // most significant digit sits at the last written slot
            emit_idx_d = count_q[AddrW-1:0];
          end
        end
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_SHOW: begin
        out_valid_o = 1'b1;
        if (out_beat && (emit_idx_q != '0)) begin
          emit_idx_d = emit_idx_q - 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      quot_q     <= '0;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      quot_q     <= quot_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  rita_divider #(
    .W (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (quot_q),
    .rsp_o      (div_rsp),
    .quotient_o (div_quot)
  );

  rita_digit_mem u_digit_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (div_rsp.remainder),
    .re_i    (mem_re),
    .raddr_i (emit_idx_q),
    .rdata_o (mem_rdata)
  );

  // read data register holds through the show state, so the beat stays stable
  assign out_data_o.digit_char = digit_to_ascii(mem_rdata);
  assign out_data_o.last       = (emit_idx_q == '0);

endmodule

// ===== rtl/rita_checker.sv =====
// ----------------------------------------------------------------------------
// rita_checker
// port-level assertions for the radix integer to ascii block
// ----------------------------------------------------------------------------
`include "radix_integer_to_ascii_defines.svh"

module rita_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rita_pkg::out_t out_data_o
);
  import rita_pkg::*;

  // a stalled output beat holds
  `RITA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled output beat changed")

  // input is never taken while a digit is on offer
  `RITA_ASSERT_ALWAYS(a_no_overlap, clk_i, !(in_ready_o && out_valid_o), "input ready while output valid")

  // an accepted input closes the input side
  `RITA_ASSERT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "ready stayed high after input beat")

  // the final digit returns the block to idle
  `RITA_ASSERT(a_idle_after_last, clk_i, rst_ni, out_valid_o && out_ready_i && out_data_o.last |=> in_ready_o && !out_valid_o, "block not idle after last digit")

  // a non-final digit is followed by a store read gap
  `RITA_ASSERT(a_gap_after_digit, clk_i, rst_ni, out_valid_o && out_ready_i && !out_data_o.last |=> !out_valid_o && !in_ready_o, "bad state after non-final digit")

endmodule

bind radix_integer_to_ascii rita_checker u_rita_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
